// ===== hw/rtl/lcae_pkg.sv =====
// Shared package of the lowest common ancestor engine: sizes, operation codes
// and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package lcae_pkg;

	localparam int ID_W      = 10;
	localparam int MAX_NODES = 1024;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int STEP_W    = $clog2(MAX_NODES + 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		RD_IN_A   = 2'd0,
		RD_B      = 2'd1,
		RD_PARENT = 2'd2
	} lcae_rd_sel_t;

	typedef struct packed {
		logic         start;
		lcae_rd_sel_t rd_sel;
		logic         path_set;
		logic         cur_from_parent;
		logic         cur_from_b;
		logic         rec_wr;
		logic         clr_start;
		logic         clr_step;
		logic         clr_present;
		logic         set_found;
		logic         set_miss;
		logic         out_load;
	} lcae_cmd_t;

	typedef struct packed {
		logic walk_ok;
		logic path_hit;
		logic clr_last;
		logic rec_ok;
	} lcae_sts_t;

endpackage

// ===== hw/rtl/lcae_datapath.sv =====
// Datapath of the lowest common ancestor engine: parent, present and path
// memories, the walk cursor, step count, sweep address and result registers.
// Depends on lcae_pkg; driven by lcae_controller.
module lcae_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lcae_pkg::lcae_cmd_t     cmd,
	output lcae_pkg::lcae_sts_t     sts,
	input  logic [lcae_pkg::ID_W-1:0] node_a,
	input  logic [lcae_pkg::ID_W-1:0] node_b,
	output logic [lcae_pkg::ID_W-1:0] ancestor,
	output logic                    status
);
	import lcae_pkg::*;

	logic [ID_W-1:0]   parent_mem [MAX_NODES];
	logic              present_mem [MAX_NODES];
	logic              path_mem [MAX_NODES];

	logic [ID_W-1:0]   parent_rd_q;
	logic              present_rd_q;
	logic              path_rd_q;

	logic [ID_W-1:0]   cur_q;
	logic [ID_W-1:0]   b_q;
	logic [STEP_W-1:0] steps_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ID_W-1:0]   ans_q;
	logic              st_q;
	logic [ID_W-1:0]   ancestor_q;
	logic              status_q;

	logic [ID_W-1:0]   rd_id;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic              cur_in_range;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_IN_A:   rd_id = node_a;
			RD_B:      rd_id = b_q;
			RD_PARENT: rd_id = parent_rd_q;
			default:   rd_id = b_q;
		endcase
	end

	assign rd_addr      = ADDR_W'(rd_id);
	assign cur_addr     = ADDR_W'(cur_q);
	assign cur_in_range = (cur_q != '0) && (32'(cur_q) < MAX_NODES);

	assign sts.walk_ok  = cur_in_range && present_rd_q && (steps_q < STEP_W'(MAX_NODES));
	assign sts.path_hit = path_rd_q;
	assign sts.clr_last = (clr_addr_q == ADDR_W'(MAX_NODES - 1));
	assign sts.rec_ok   = cur_in_range;

	// Memories: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.rec_wr) begin
			parent_mem[cur_addr] <= b_q;
		end
		parent_rd_q <= parent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_wr) begin
			present_mem[cur_addr] <= 1'b1;
		end else if (cmd.clr_step && cmd.clr_present) begin
			present_mem[clr_addr_q] <= 1'b0;
		end
		present_rd_q <= present_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.path_set) begin
			path_mem[cur_addr] <= 1'b1;
		end else if (cmd.clr_step) begin
			path_mem[clr_addr_q] <= 1'b0;
		end
		path_rd_q <= path_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step && !sts.clr_last) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q   <= node_a;
			b_q     <= node_b;
			steps_q <= '0;
			ans_q   <= '0;
			st_q    <= 1'b0;
		end else begin
			if (cmd.cur_from_parent) begin
				cur_q   <= parent_rd_q;
				steps_q <= steps_q + 1'b1;
			end else if (cmd.cur_from_b) begin
				cur_q   <= b_q;
				steps_q <= '0;
			end
			if (cmd.set_found) begin
				ans_q <= cur_q;
				st_q  <= 1'b0;
			end else if (cmd.set_miss) begin
				ans_q <= '0;
				st_q  <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			ancestor_q <= ans_q;
			status_q   <= st_q;
		end
	end

	assign ancestor = ancestor_q;
	assign status   = status_q;

endmodule

// ===== hw/rtl/lcae_controller.sv =====
// Controller of the lowest common ancestor engine: sequences clear, record
// and query transactions and owns the input and output handshakes.
// Depends on lcae_pkg; commands lcae_datapath.
module lcae_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	output logic                out_valid,
	input  logic                out_ready,
	input  lcae_pkg::lcae_sts_t sts,
	output lcae_pkg::lcae_cmd_t cmd
);
	import lcae_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_REC    = 7'b0000010,
		S_WALK_A = 7'b0000100,
		S_WALK_B = 7'b0001000,
		S_SWEEP  = 7'b0010000,
		S_FIN    = 7'b0100000,
		S_SPARE  = 7'b1000000
	} lcae_state_t;

	lcae_state_t state_q, state_d;
	logic        clr_all_q, clr_all_d;
	logic        init_q, init_d;
	logic        out_valid_q;
	logic        accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = RD_B;
		state_d   = state_q;
		clr_all_d = clr_all_q;
		init_d    = init_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start  = 1'b1;
					cmd.rd_sel = RD_IN_A;
					unique case (op)
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							clr_all_d     = 1'b1;
							state_d       = S_SWEEP;
						end
						OP_RECORD: state_d = S_REC;
						OP_QUERY:  state_d = S_WALK_A;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_REC: begin
				cmd.rec_wr = sts.rec_ok;
				state_d    = S_FIN;
			end
			S_WALK_A: begin
				if (sts.walk_ok) begin
					cmd.path_set        = 1'b1;
					cmd.cur_from_parent = 1'b1;
					cmd.rd_sel          = RD_PARENT;
				end else begin
					cmd.cur_from_b = 1'b1;
					cmd.rd_sel     = RD_B;
					state_d        = S_WALK_B;
				end
			end
			S_WALK_B: begin
				if (sts.walk_ok && sts.path_hit) begin
					cmd.set_found = 1'b1;
					cmd.clr_start = 1'b1;
					clr_all_d     = 1'b0;
					state_d       = S_SWEEP;
				end else if (sts.walk_ok) begin
					cmd.cur_from_parent = 1'b1;
					cmd.rd_sel          = RD_PARENT;
				end else begin
					cmd.set_miss  = 1'b1;
					cmd.clr_start = 1'b1;
					clr_all_d     = 1'b0;
					state_d       = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.clr_step    = 1'b1;
				cmd.clr_present = clr_all_q;
				if (sts.clr_last) begin
					init_d  = 1'b0;
					state_d = init_q ? S_IDLE : S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Reset starts in a full sweep so that both mark memories read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			clr_all_q   <= 1'b1;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_all_q <= clr_all_d;
			init_q    <= init_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/lowest_common_ancestor_engine_unit.sv =====
// Top level of the lowest common ancestor engine.
// Depends on lcae_pkg, lcae_controller and lcae_datapath.
//
// The engine keeps a tree of up to MAX_NODES - 1 numbered nodes as a parent
// table and answers one result transaction for every input transaction.
// Operation clear drops every recorded node, record stores node_a with parent
// node_b (node zero and ids out of range are ignored), and query returns the
// lowest common ancestor of node_a and node_b, or status 1 with ancestor 0
// when node_a is not recorded or the climb from node_b never meets its path.
// Unused operation codes answer ancestor 0 and status 0. One transaction is
// worked at a time, and all work goes through memories with one write port
// and one registered read port each, one read per cycle. A clear sweeps the
// mark memories one entry per cycle. A query marks each ancestor of node_a
// on the path, climbs from node_b until it meets a marked node, then sweeps
// to clear the path marks. After reset the engine runs a clearing pass before
// it raises in_ready. A finished result sits in an output register, so the
// next transaction is taken while the result waits for out_ready.
module lowest_common_ancestor_engine_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                op,
	input  logic [lcae_pkg::ID_W-1:0] node_a,
	input  logic [lcae_pkg::ID_W-1:0] node_b,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lcae_pkg::ID_W-1:0] ancestor,
	output logic                      status
);
	import lcae_pkg::*;

	lcae_cmd_t cmd;
	lcae_sts_t sts;

	// The controller sequences each transaction and drives the handshakes.
	lcae_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the tree, the marks and the result registers.
	lcae_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.node_a   (node_a),
		.node_b   (node_b),
		.ancestor (ancestor),
		.status   (status)
	);

	// A failed query never reports a node.
	a_miss_has_no_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> ancestor == '0)
		else $error("not-found result carries a nonzero ancestor");

	// Once a transaction is taken, the engine is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("engine ready again right after taking a transaction");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register loaded while a result is pending");

	// The path memory is never marked and swept in the same cycle.
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.path_set && cmd.clr_step))
		else $error("path mark written and swept in the same cycle");

endmodule

// ===== verif/lowest_common_ancestor_engine_unit_test.sv =====
// Testbench for the lowest common ancestor engine: builds parent tables, asks
// for common ancestors and checks every answer against a behavioral predictor.
// Depends on lcae_pkg and lowest_common_ancestor_engine_unit.
`timescale 1ns / 100ps

module lowest_common_ancestor_engine_unit_test;

	import lcae_pkg::*;

	// The package names only the three real operations; the fourth code does nothing.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         NODE_TOP  = MAX_NODES - 1;
	// A query may walk the table three times; the tail wait covers one such query.
	localparam int         TAIL_CYCLES = 3 * MAX_NODES + 64;

	typedef struct packed {
		logic [ID_W-1:0] ancestor;
		logic            status;
	} lca_result_t;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	logic [1:0]      op        = OP_CLEAR;
	logic [ID_W-1:0] node_a    = '0;
	logic [ID_W-1:0] node_b    = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [ID_W-1:0] ancestor;
	logic            status;

	// Shadow copy of the engine's tree, kept by the predictor.
	logic [ID_W-1:0] shadow_parent [MAX_NODES];
	bit              shadow_present [MAX_NODES];

	lca_result_t     answer_q [$];
	int              mismatch_count = 0;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	int              hold_request   = 0;

	lowest_common_ancestor_engine_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ancestor  (ancestor),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the engine hangs; far beyond the slowest correct run.
	initial begin
		#60_000_000;
		$display("lowest_common_ancestor_engine_unit_test failed");
		$finish;
	end

	function automatic bit is_recorded(input logic [ID_W-1:0] id);
		return id != '0 && int'(id) < MAX_NODES && shadow_present[id];
	endfunction

	// Applies one transaction to the shadow tree and returns the answer the
	// engine must give. Both climbs are bounded so that cyclic parent links
	// end; a second climb that reaches the bound or leaves the tree misses.
	function automatic lca_result_t predict_lca(input logic [1:0] code,
			input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
		lca_result_t     res;
		bit              on_path [MAX_NODES];
		logic [ID_W-1:0] cur;
		bit              found;
		res = '{ancestor: '0, status: 1'b0};
		case (code)
			OP_CLEAR: begin
				foreach (shadow_present[i]) shadow_present[i] = 1'b0;
			end
			OP_RECORD: begin
				if (a != '0 && int'(a) < MAX_NODES) begin
					shadow_parent[a]  = b;
					shadow_present[a] = 1'b1;
				end
			end
			OP_QUERY: begin
				foreach (on_path[i]) on_path[i] = 1'b0;
				cur = a;
				for (int s = 0; s < MAX_NODES && is_recorded(cur); s++) begin
					on_path[cur] = 1'b1;
					cur = shadow_parent[cur];
				end
				cur   = b;
				found = 1'b0;
				for (int s = 0; s < MAX_NODES && !found && is_recorded(cur); s++) begin
					if (on_path[cur])
						found = 1'b1;
					else
						cur = shadow_parent[cur];
				end
				if (found)
					res.ancestor = cur;
				else
					res.status = 1'b1;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Offers one transaction after a random idle gap and waits for acceptance.
	// Valid stays high on return, so a back-to-back item needs no idle gap.
	task automatic send_txn(input logic [1:0] code, input logic [ID_W-1:0] a,
			input logic [ID_W-1:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		node_a   <= a;
		node_b   <= b;
		do
			@(posedge clk);
		while (!in_ready);
		answer_q.push_back(predict_lca(code, a, b));
	endtask

	// Drops valid and waits until every answer has come back.
	task automatic drain_answers();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (answer_q.size() != 0);
	endtask

	// Receiver: random stalls, plus a long hold-off when a test requests one.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result transaction is matched against the oldest answer.
	always @(posedge clk) begin : result_check
		lca_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result ancestor=%0d status=%0b",
					ancestor, status));
			end else begin
				want = answer_q.pop_front();
				if (ancestor !== want.ancestor)
					report_mismatch($sformatf("ancestor %0d, expected %0d",
						ancestor, want.ancestor));
				if (status !== want.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						status, want.status));
			end
		end
	end

	// Hand-built tree: empty tree, ignored node zero, the all-ones id as root,
	// siblings, a node queried against itself, missing ids on either side, a
	// parent that was never recorded, re-recording, the unused code, a cycle
	// in the parent links (both climbs hit their bound), and a clear.
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_txn(OP_QUERY, 10'd5, 10'd5);
		send_txn(OP_RECORD, 10'd0, 10'd7);
		send_txn(OP_RECORD, 10'd1023, 10'd0);
		send_txn(OP_RECORD, 10'd1, 10'd1023);
		send_txn(OP_RECORD, 10'd2, 10'd1);
		send_txn(OP_RECORD, 10'd3, 10'd1);
		send_txn(OP_QUERY, 10'd2, 10'd3);
		send_txn(OP_QUERY, 10'd3, 10'd1023);
		send_txn(OP_QUERY, 10'd1023, 10'd2);
		send_txn(OP_QUERY, 10'd2, 10'd2);
		send_txn(OP_QUERY, 10'd0, 10'd2);
		send_txn(OP_QUERY, 10'd2, 10'd0);
		send_txn(OP_QUERY, 10'd2, 10'd700);
		send_txn(OP_RECORD, 10'd4, 10'd999);
		send_txn(OP_QUERY, 10'd4, 10'd2);
		send_txn(OP_RECORD, 10'd3, 10'd4);
		send_txn(OP_QUERY, 10'd3, 10'd4);
		send_txn(OP_UNUSED, 10'd1023, 10'd1023);
		send_txn(OP_RECORD, 10'd5, 10'd6);
		send_txn(OP_RECORD, 10'd6, 10'd5);
		send_txn(OP_QUERY, 10'd5, 10'd6);
		send_txn(OP_QUERY, 10'd3, 10'd5);
		send_txn(OP_CLEAR, 10'd1023, 10'd1023);
		send_txn(OP_QUERY, 10'd2, 10'd3);
		drain_answers();
	endtask

	// One well-formed forest: clear, record nodes whose parents are mostly
	// earlier nodes, then query pairs from the forest with some noise mixed in.
	task automatic run_forest_round(input int node_cnt, input int query_cnt);
		logic [ID_W-1:0] ids [$];
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] par;
		int              pick;
		send_txn(OP_CLEAR, ID_W'($urandom), ID_W'($urandom));
		repeat (node_cnt) begin
			id   = ID_W'($urandom_range(1, NODE_TOP));
			pick = $urandom_range(99);
			if (ids.size() == 0 || pick < 12)
				par = '0;
			else if (pick < 20)
				par = ID_W'($urandom_range(1, NODE_TOP));
			else if (pick < 55)
				par = ids[ids.size() - 1];
			else
				par = ids[$urandom_range(ids.size() - 1)];
			send_txn(OP_RECORD, id, par);
			ids.push_back(id);
		end
		repeat (query_cnt) begin
			pick = $urandom_range(99);
			if (pick < 78)
				send_txn(OP_QUERY, ids[$urandom_range(ids.size() - 1)],
					ids[$urandom_range(ids.size() - 1)]);
			else if (pick < 86)
				send_txn(OP_QUERY, ids[$urandom_range(ids.size() - 1)],
					ID_W'($urandom));
			else if (pick < 93)
				send_txn(OP_QUERY, ID_W'($urandom),
					ids[$urandom_range(ids.size() - 1)]);
			else
				send_txn(OP_UNUSED, ID_W'($urandom), ID_W'($urandom));
		end
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int rounds);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (rounds)
			run_forest_round($urandom_range(4, 10), $urandom_range(4, 8));
		drain_answers();
	endtask

	// The receiver holds off for a long stretch while records keep coming, so
	// the output register fills and the engine has to drop in_ready.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 4000;
		repeat (6)
			send_txn(OP_RECORD, ID_W'($urandom_range(1, NODE_TOP)), '0);
		send_txn(OP_UNUSED, ID_W'($urandom), ID_W'($urandom));
		drain_answers();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_phase(0, 0, 3);
		test_random_phase(46, 0, 3);
		test_random_phase(0, 46, 3);
		test_random_phase(26, 26, 3);
		test_output_backpressure();
		// Leave room for any stray result transaction to show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("lowest_common_ancestor_engine_unit_test passed");
		else
			$display("lowest_common_ancestor_engine_unit_test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lcae_pkg.sv
hw/rtl/lcae_datapath.sv
hw/rtl/lcae_controller.sv
hw/rtl/lowest_common_ancestor_engine_unit.sv
verif/lowest_common_ancestor_engine_unit_test.sv
